@@ rtl/core/scba_pkg.sv @@
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types and constants for the size-class bitmap allocator core:
// request and response beats, status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package scba_pkg;

	// Geometry of the allocator.
	localparam int NUM_CLASSES      = 16;
	localparam int SLOTS_PER_CLASS  = 64;
	localparam int MIN_ELEMENT_LOG2 = 4;

	// Fixed field widths of the beats.
	localparam int REQ_BYTES_W = 20;
	localparam int SLOT_W      = 6;
	localparam int SCLASS_W    = 4;
	localparam int STATUS_W    = 3;

	// Internal class number: wide enough for the bit length of a request.
	localparam int CLS_W       = $clog2(REQ_BYTES_W + 1);
	localparam int CLS_IDX_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int SLOT_IDX_W  = $clog2(SLOTS_PER_CLASS);

	// Request operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Response status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_ZERO   = 3'd1,
		ST_BIG    = 3'd2,
		ST_FULL   = 3'd3,
		ST_DOUBLE = 3'd4
	} status_e_t;

	// Request beat.
	typedef struct packed {
		logic                   op;
		logic [REQ_BYTES_W-1:0] request_bytes;
		logic [SLOT_W-1:0]      free_slot;
	} req_t;

	// Response beat.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SCLASS_W-1:0] size_class;
		logic [SLOT_W-1:0]   slot;
	} rsp_t;

	// Controller states.
	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;
		logic commit;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic out_blocked;
	} stat_t;

endpackage

@@ rtl/core/scba_ctrl.sv @@
// ----------------------------------------------------------------------------
// scba_ctrl
// Controller for the allocator: takes a request beat when idle, then commits
// it to the datapath once the response register can accept a new beat.
// ----------------------------------------------------------------------------
module scba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  scba_pkg::stat_t stat,
	output scba_pkg::cmd_t  cmd
);
	import scba_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!stat.out_blocked) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		req_stall  = 1'b1;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				cmd.load  = req_valid;
			end
			S_EXEC: begin
				cmd.commit = !stat.out_blocked;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

@@ rtl/core/scba_dpath.sv @@
// ----------------------------------------------------------------------------
// scba_dpath
// Datapath for the allocator: decodes the size class of a request, holds the
// per-class occupancy bitmaps, finds the lowest free slot, and keeps the
// response register.
// ----------------------------------------------------------------------------
module scba_dpath (
	input  logic           clk,
	input  logic           arst_n,
	input  scba_pkg::req_t req,
	input  scba_pkg::cmd_t cmd,
	output scba_pkg::stat_t stat,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output scba_pkg::rsp_t rsp
);
	import scba_pkg::*;

	localparam logic [CLS_W-1:0] MIN_LOG2_C    = CLS_W'(MIN_ELEMENT_LOG2);
	localparam logic [CLS_W:0]   NUM_CLASSES_C = (CLS_W + 1)'(NUM_CLASSES);
	localparam logic [SLOT_W:0]  SLOTS_C       = (SLOT_W + 1)'(SLOTS_PER_CLASS);

	// Number of significant bits in a value.
	function automatic logic [CLS_W-1:0] bit_len(input logic [REQ_BYTES_W-1:0] v);
		logic [CLS_W-1:0] n;
		n = '0;
		for (int i = 0; i < REQ_BYTES_W; i++) begin
			if (v[i]) begin
				n = CLS_W'(i + 1);
			end
		end
		return n;
	endfunction

	logic [SLOTS_PER_CLASS-1:0] map_q [NUM_CLASSES];

	logic                   op_q;
	logic [SLOT_W-1:0]      fslot_q;
	logic [CLS_W-1:0]       cls_q;
	logic                   zero_q;
	logic                   big_q;

	logic [REQ_BYTES_W-1:0] bytes_m1;
	logic [CLS_W-1:0]       blen;
	logic [CLS_W-1:0]       cls_d;

	logic [CLS_IDX_W-1:0]       idx;
	logic [SLOTS_PER_CLASS-1:0] entry;
	logic [SLOTS_PER_CLASS-1:0] free_bits;
	logic [SLOT_IDX_W-1:0]      alloc_idx;
	logic [SLOT_IDX_W-1:0]      fslot_idx;
	logic                       fslot_ok;
	logic                       fslot_used;
	logic                       map_we;
	logic [SLOTS_PER_CLASS-1:0] map_wdata;
	rsp_t                       rsp_d;
	logic                       rsp_valid_q;
	rsp_t                       rsp_q;

	// Size class decode at acceptance.
	always_comb begin
		bytes_m1 = req.request_bytes - REQ_BYTES_W'(1);
		blen     = bit_len(bytes_m1);
		cls_d    = (blen > MIN_LOG2_C) ? (blen - MIN_LOG2_C) : '0;
	end

	// Request registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= req.op;
			fslot_q <= req.free_slot;
			cls_q   <= cls_d;
			zero_q  <= (req.request_bytes == '0);
			big_q   <= ({1'b0, cls_d} >= NUM_CLASSES_C);
		end
	end

	// Bitmap lookup and lowest free slot search.
	always_comb begin
		idx       = cls_q[CLS_IDX_W-1:0];
		entry     = map_q[idx];
		free_bits = ~entry;
		alloc_idx = '0;
		for (int i = SLOTS_PER_CLASS - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				alloc_idx = SLOT_IDX_W'(i);
			end
		end
		fslot_ok   = ({1'b0, fslot_q} < SLOTS_C);
		fslot_idx  = fslot_q[SLOT_IDX_W-1:0];
		fslot_used = fslot_ok && entry[fslot_idx];
	end

	// Response and bitmap update.
	always_comb begin
		rsp_d.status     = ST_OK;
		rsp_d.size_class = cls_q[SCLASS_W-1:0];
		rsp_d.slot       = '0;
		map_we           = 1'b0;
		map_wdata        = entry;
		if (zero_q) begin
			rsp_d.status     = ST_ZERO;
			rsp_d.size_class = '0;
		end else if (big_q) begin
			rsp_d.status     = ST_BIG;
			rsp_d.size_class = '0;
		end else if (op_q == OP_ALLOC) begin
			if (free_bits == '0) begin
				rsp_d.status = ST_FULL;
			end else begin
				rsp_d.slot           = SLOT_W'(alloc_idx);
				map_we               = 1'b1;
				map_wdata[alloc_idx] = 1'b1;
			end
		end else begin
			rsp_d.slot = fslot_q;
			if (!fslot_used) begin
				rsp_d.status = ST_DOUBLE;
			end else begin
				map_we               = 1'b1;
				map_wdata[fslot_idx] = 1'b0;
			end
		end
	end

	// Occupancy bitmaps, all slots free after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				map_q[c] <= '0;
			end
		end else if (cmd.commit && map_we) begin
			map_q[idx] <= map_wdata;
		end
	end

	// Response register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response register: payload.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign stat.out_blocked = rsp_valid_q && rsp_stall;
	assign rsp_valid        = rsp_valid_q;
	assign rsp              = rsp_q;

endmodule

@@ rtl/core/size_class_bitmap_allocator_core.sv @@
// ----------------------------------------------------------------------------
// size_class_bitmap_allocator_core
// Sequencing: the edge that accepts a request loads the request registers;
// the execute step then looks up the bitmaps and loads the response register.
// No new request is taken until the execute step is done, and a stalled
// response holds back the execute step. A request may be accepted while the
// previous response still waits.
// Reset: asynchronous; all occupancy bitmaps are cleared at once, no sweep.
// ----------------------------------------------------------------------------
module size_class_bitmap_allocator_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  scba_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output scba_pkg::rsp_t rsp
);
	import scba_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencing of each request.
	scba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Class decode, bitmaps and response register.
	scba_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ rtl/core/scba_checker.sv @@
// ----------------------------------------------------------------------------
// scba_checker
// Port-level checks on the allocator core: response beat handshake, the
// busy window after a request beat, and the shape of error responses.
// ----------------------------------------------------------------------------
module scba_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input scba_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input scba_pkg::rsp_t rsp
);
	import scba_pkg::*;

	// A stalled response beat stays valid.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response beat dropped while stalled");

	// A stalled response beat keeps its payload.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("response payload changed while stalled");

	// The core is busy in the cycle after taking a request beat.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous one in flight");

	// Zero-size and oversize responses carry neither class nor slot.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_ZERO || rsp.status == ST_BIG)
		|-> rsp.size_class == '0 && rsp.slot == '0)
		else $error("error response carries class or slot");

	// A class-full response reports slot zero.
	a_full_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.slot == '0)
		else $error("class-full response carries a slot");

endmodule

bind size_class_bitmap_allocator_core scba_checker u_scba_checker (.*);

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the size-class bitmap allocator core. Request beats
// are allocates and frees across every size class, with zero and oversize
// requests, classes filled past capacity and frees of slots not in use. A
// scoreboard keeps its own copy of the occupancy bitmaps and predicts every
// response beat, which is compared field by field as it leaves the core.
// Both sides idle in random bursts, except over the final part of the run.
// ----------------------------------------------------------------------------
module tb;

	import scba_pkg::*;

	localparam int NUM_ITEMS   = 1000;
	localparam int CALM_ITEMS  = 120;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 10;
	localparam int MAX_BYTES   = (1 << REQ_BYTES_W) - 1;
	localparam int TOP_BYTES   = 1 << (NUM_CLASSES + MIN_ELEMENT_LOG2 - 1);

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// Set for the last stretch of the run: no idling on either side.
	bit calm;
	int n_sent;

	// Occupancy tracker: mirrors the bitmaps and holds the awaited responses.
	class occupancy_tracker;
		bit [63:0] occ [NUM_CLASSES];
		rsp_t      awaited [$];
		int        errors;

		function new();
			foreach (occ[i])
				occ[i] = '0;
			errors = 0;
		endfunction

		// Work out the response to an accepted request beat and update the bitmaps.
		function void note_request(req_t r);
			rsp_t                   e;
			logic [REQ_BYTES_W-1:0] m1;
			int                     blen;
			int                     cls;
			int                     hit;
			e    = '0;
			blen = 0;
			hit  = -1;
			if (r.request_bytes == '0) begin
				e.status = ST_ZERO;
			end else begin
				m1 = r.request_bytes - 1'b1;
				for (int b = 0; b < REQ_BYTES_W; b++)
					if (m1[b])
						blen = b + 1;
				cls = (blen > MIN_ELEMENT_LOG2) ? blen - MIN_ELEMENT_LOG2 : 0;
				if (cls >= NUM_CLASSES) begin
					e.status = ST_BIG;
				end else if (r.op == OP_ALLOC) begin
					e.size_class = cls[SCLASS_W-1:0];
					for (int s = SLOTS_PER_CLASS - 1; s >= 0; s--)
						if (!occ[cls][s])
							hit = s;
					if (hit < 0) begin
						e.status = ST_FULL;
					end else begin
						occ[cls][hit] = 1'b1;
						e.status      = ST_OK;
						e.slot        = hit[SLOT_W-1:0];
					end
				end else begin
					e.size_class = cls[SCLASS_W-1:0];
					e.slot       = r.free_slot;
					if (!occ[cls][r.free_slot]) begin
						e.status = ST_DOUBLE;
					end else begin
						occ[cls][r.free_slot] = 1'b0;
						e.status              = ST_OK;
					end
				end
			end
			awaited.push_back(e);
		endfunction

		// Compare a response beat with the oldest awaited one.
		function void check_response(rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				$error("response beat with nothing awaited: status %0d, class %0d, slot %0d",
					got.status, got.size_class, got.slot);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status) begin
				$error("status mismatch: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.size_class !== want.size_class) begin
				$error("size_class mismatch: expected %0d, actual %0d",
					want.size_class, got.size_class);
				errors++;
			end
			if (got.slot !== want.slot) begin
				$error("slot mismatch: expected %0d, actual %0d", want.slot, got.slot);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function int free_count(int c);
			int n;
			n = 0;
			for (int s = 0; s < SLOTS_PER_CLASS; s++)
				if (!occ[c][s])
					n++;
			return n;
		endfunction

		// A random slot in use within the class, or -1 when the class is empty.
		function int pick_used_slot(int c);
			int n;
			int k;
			n = SLOTS_PER_CLASS - free_count(c);
			if (n == 0)
				return -1;
			k = $urandom_range(0, n - 1);
			for (int s = 0; s < SLOTS_PER_CLASS; s++) begin
				if (occ[c][s]) begin
					if (k == 0)
						return s;
					k--;
				end
			end
			return -1;
		endfunction
	endclass

	occupancy_tracker tracker;

	// Clock: 2 ns period.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	size_class_bitmap_allocator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// A byte count that falls in the given class, often at either edge of it.
	function automatic logic [REQ_BYTES_W-1:0] bytes_for_class(input int c);
		int unsigned lo;
		int unsigned hi;
		if (c == 0) begin
			lo = 1;
			hi = 1 << MIN_ELEMENT_LOG2;
		end else begin
			lo = (1 << (c + MIN_ELEMENT_LOG2 - 1)) + 1;
			hi = 1 << (c + MIN_ELEMENT_LOG2);
		end
		case ($urandom_range(0, 3))
			0: return lo[REQ_BYTES_W-1:0];
			1: return hi[REQ_BYTES_W-1:0];
			default: return REQ_BYTES_W'($urandom_range(hi, lo));
		endcase
	endfunction

	// Favour a few classes so that they fill up, but reach every one.
	function automatic int pick_class();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1;
			2: return NUM_CLASSES - 1;
			default: return $urandom_range(0, NUM_CLASSES - 1);
		endcase
	endfunction

	// Byte count for the mixed traffic: mostly valid, sometimes zero or oversize.
	function automatic logic [REQ_BYTES_W-1:0] any_bytes();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return REQ_BYTES_W'($urandom_range(MAX_BYTES, TOP_BYTES + 1));
			default: return bytes_for_class($urandom_range(0, NUM_CLASSES - 1));
		endcase
	endfunction

	// Drive one request beat and return at the edge that accepts it. The stall
	// is sampled mid-cycle, where it is settled until the next rising edge.
	task automatic send_beat(input logic op, input logic [REQ_BYTES_W-1:0] bytes,
			input logic [SLOT_W-1:0] fslot);
		req_t r;
		r.op            = op;
		r.request_bytes = bytes;
		r.free_slot     = fslot;
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do
			@(negedge clk);
		while (req_stall);
		tracker.note_request(r);
		n_sent++;
		@(posedge clk);
	endtask

	// Hold the request side quiet until every awaited response has come.
	task automatic wait_drained();
		if (req_valid)
			req_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// Response beats are checked mid-cycle, ahead of the edge that takes them.
	always @(negedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			tracker.check_response(rsp);
	end

	// Response back-pressure: random stall bursts between quiet stretches.
	initial begin : rsp_backpressure
		int run;
		rsp_stall <= 1'b0;
		forever begin
			run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			repeat (run) @(posedge clk);
			if (!calm && $urandom_range(0, 1) == 1) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// Watchdog on the whole run.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Main sequence: reset, directed beats, a class fill, random episodes, drain and verdict.
	initial begin : stimulus
		int kind;
		int c;
		int n;
		int s;
		tracker   = new();
		calm      = 1'b0;
		n_sent    = 0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero size and oversize on both operations, class edges,
		// reuse of the lowest slot, and frees of slots not in use.
		send_beat(OP_ALLOC, '0, '0);
		send_beat(OP_FREE, '0, 6'd63);
		send_beat(OP_ALLOC, REQ_BYTES_W'(MAX_BYTES), 6'd63);
		send_beat(OP_FREE, REQ_BYTES_W'(TOP_BYTES + 1), 6'd5);
		send_beat(OP_ALLOC, 20'd1, '0);
		send_beat(OP_ALLOC, 20'd16, '0);
		send_beat(OP_ALLOC, 20'd17, '0);
		send_beat(OP_ALLOC, REQ_BYTES_W'(TOP_BYTES), '0);
		send_beat(OP_ALLOC, REQ_BYTES_W'((TOP_BYTES >> 1) + 1), 6'd63);
		send_beat(OP_FREE, 20'd16, 6'd1);
		send_beat(OP_FREE, 20'd16, 6'd1);
		send_beat(OP_FREE, 20'd8, 6'd63);
		send_beat(OP_ALLOC, 20'd2, '0);
		send_beat(OP_FREE, REQ_BYTES_W'(TOP_BYTES), '0);
		send_beat(OP_FREE, 20'd32, '0);
		send_beat(OP_ALLOC, 20'd33, 6'd42);
		send_beat(OP_FREE, 20'd64, '0);
		send_beat(OP_FREE, 20'd64, '0);
		send_beat(OP_ALLOC, 20'd65, 6'd21);
		send_beat(OP_FREE, 20'd15, 6'd0);
		send_beat(OP_FREE, 20'd1, 6'd0);
		wait_drained();

		// Fill one class past capacity before the random traffic starts.
		c = pick_class();
		n = tracker.free_count(c) + $urandom_range(1, 3);
		for (int i = 0; i < n; i++)
			send_beat(OP_ALLOC, bytes_for_class(c), SLOT_W'($urandom_range(0, 63)));

		// Random episodes: fills, drains and mixed traffic.
		while (n_sent < NUM_ITEMS) begin
			if (n_sent >= NUM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			kind = $urandom_range(0, 9);
			c    = pick_class();
			if (kind <= 2) begin
				n = tracker.free_count(c) + $urandom_range(0, 3);
				for (int i = 0; i < n; i++)
					send_beat(OP_ALLOC, bytes_for_class(c), SLOT_W'($urandom_range(0, 63)));
			end else if (kind <= 5) begin
				n = $urandom_range(1, 40);
				for (int i = 0; i < n; i++) begin
					s = tracker.pick_used_slot(c);
					if (s < 0 || $urandom_range(0, 7) == 0)
						s = $urandom_range(0, 63);
					send_beat(OP_FREE, bytes_for_class(c), SLOT_W'(s));
				end
			end else if (kind <= 8) begin
				n = $urandom_range(5, 30);
				for (int i = 0; i < n; i++)
					send_beat(1'($urandom_range(0, 1)), any_bytes(),
						SLOT_W'($urandom_range(0, 63)));
			end else begin
				wait_drained();
			end
		end

		// Drain and let the core settle before the verdict.
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (tracker.pending() != 0) begin
			$error("%0d response beats never arrived", tracker.pending());
			tracker.errors++;
		end
		if (tracker.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/scba_pkg.sv
rtl/core/scba_ctrl.sv
rtl/core/scba_dpath.sv
rtl/core/size_class_bitmap_allocator_core.sv
rtl/core/scba_checker.sv
sim/tb.sv
